[rtl/core/segregated_free_list_allocator_assert.svh]
// Assertion macros used by the allocator top level.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sfl_pkg.sv]
// Shared types and constants of the segregated free-list allocator.
package sfl_pkg;

  localparam int ADDR_W   = 24;
  localparam int POOL_W   = 25;
  localparam int COPY_W   = 21;
  localparam int CLASS_W  = 5;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CAP_LOG  = 24;   // bump limit never exceeds 2^24

  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(1) << CAP_LOG;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_GROW  = 2'd1,
    FUNC_FREE  = 2'd2,
    FUNC_FLUSH = 2'd3
  } sfl_func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_BADCLASS  = 3'd2,
    ST_NOTLARGER = 3'd3,
    ST_FULL      = 3'd4
  } sfl_status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CLASS_W-1:0] size_class;
    logic [CLASS_W-1:0] old_class;
    logic [ADDR_W-1:0]  location;
  } sfl_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
    logic [COPY_W-1:0]   copy_bytes;
    logic [POOL_W-1:0]   used_bytes;
  } sfl_out_t;

  // Decision made in the first stage, finished once stack read data is back.
  typedef struct packed {
    sfl_status_t        status;
    logic               from_mem;
    logic [ADDR_W-1:0]  carve_addr;
    logic [COPY_W-1:0]  copy_bytes;
    logic [POOL_W-1:0]  used_bytes;
  } sfl_dec_t;

endpackage

[rtl/core/sfl_stream_if.sv]
// Valid/ready channel carrying one word of type T.
interface sfl_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/segregated_free_list_allocator.sv]
// Segregated free-list allocator, top level. Requests enter an input
// register; once stage B can take it, the class control decides the operation,
// updates the per-class stack counts and the bump pointer, writes a pushed
// block offset into the stack memory and reads the offset to be popped.
// Stage B merges the registered stack read data with the
// decision, and the result lands in an output register. One request is
// taken every cycle unless output back-pressure stalls the pipeline; a
// result passes the input register, the stage B register and stack read
// port, and the output register before it is offered. Each class
// stack is one slice of a single memory with one write and one read per
// cycle, so grow (pop the new class, push the old one) fits one pass. The
// stack memory needs no clearing after reset: only entries below a class
// count are ever used. The pool size register is written through the
// configuration channel, which is always ready; write it only while idle.
`include "segregated_free_list_allocator_assert.svh"

module segregated_free_list_allocator #(
  parameter int MIN_CLASS   = 4,
  parameter int MAX_CLASS   = 11,
  parameter int STACK_DEPTH = 16,
  parameter int ADDR_BITS   = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  sfl_stream_if.sink   in_chan,
  sfl_stream_if.source out_chan,
  sfl_stream_if.sink   cfg_chan
);
  import sfl_pkg::*;

  localparam int NCLASS    = (MAX_CLASS >= MIN_CLASS) ? (MAX_CLASS - MIN_CLASS + 1) : 1;
  localparam int CIDX_W    = (NCLASS > 1) ? $clog2(NCLASS) : 1;
  localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MADDR_W   = CIDX_W + SLOT_W;
  localparam int MEM_DEPTH = NCLASS * (1 << SLOT_W);
  localparam int ENTRY_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

  // stage A: request register
  logic     a_valid_r;
  sfl_in_t  a_op_r;
  logic     a_adv;

  // stage B: decision plus registered stack read
  logic     b_valid_r;
  sfl_dec_t b_dec_r;
  sfl_dec_t dec;
  logic     b_adv;
  logic [ENTRY_W-1:0] mem_q;
  sfl_out_t b_word;

  // output register
  logic     out_valid_r;
  sfl_out_t out_word_r;

  logic               mem_we;
  logic [MADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // assertion terms
  logic     out_failed, out_zeroed, b_pop_stall;

  // B moves when the output register is free or being drained; A moves
  // (and commits its state update) only when B can take it.
  assign b_adv = b_valid_r && (!out_valid_r || out_chan.ready);
  assign a_adv = a_valid_r && (!b_valid_r || b_adv);

  assign in_chan.ready  = !a_valid_r || a_adv;
  assign cfg_chan.ready = 1'b1;

  sfl_class_ctrl #(
    .MIN_CLASS   (MIN_CLASS),
    .MAX_CLASS   (MAX_CLASS),
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .CIDX_W      (CIDX_W),
    .SLOT_W      (SLOT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_chan.valid),
    .cfg_data  (POOL_W'(cfg_chan.data)),
    .op_go     (a_adv),
    .op        (a_op_r),
    .dec       (dec),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr)
  );

  // read enable follows a_adv so the data holds while B is stalled
  sfl_stack_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MADDR_W),
    .DW    (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (a_adv),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // popped blocks take their offset from memory, carved ones from the
  // bump pointer; failures already carry zero address and copy length
  assign b_word.address    = b_dec_r.from_mem ? ADDR_W'(mem_q) : b_dec_r.carve_addr;
  assign b_word.status     = b_dec_r.status;
  assign b_word.copy_bytes = b_dec_r.copy_bytes;
  assign b_word.used_bytes = b_dec_r.used_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      a_op_r <= in_chan.data;
    end
    if (a_adv) begin
      b_dec_r <= dec;
    end
    if (b_adv) begin
      out_word_r <= b_word;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  assign out_failed  = out_chan.valid && (out_chan.data.status != ST_OK);
  assign out_zeroed  = (out_chan.data.address == '0) && (out_chan.data.copy_bytes == '0);
  assign b_pop_stall = b_valid_r && !b_adv && b_dec_r.from_mem;

  `SFL_ASSERT_NOW(a_fail_zeroed, clk, rst_n, out_failed, out_zeroed, "failed result not zeroed")
  `SFL_ASSERT_NEXT(a_stage_b_load, clk, rst_n, a_adv, b_valid_r, "request did not reach stage B")
  `SFL_ASSERT_NEXT(a_rdata_hold, clk, rst_n, b_pop_stall, $stable({mem_q, b_dec_r}), "B data moved")

endmodule

[rtl/core/sfl_stack_mem.sv]
// Free-stack storage: one write port, one registered read port.
module sfl_stack_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/sfl_class_ctrl.sv]
// Class counts, bump pointer and pool register; decides each operation.
module sfl_class_ctrl #(
  parameter int MIN_CLASS   = 4,
  parameter int MAX_CLASS   = 11,
  parameter int STACK_DEPTH = 16,
  parameter int ADDR_BITS   = 24,
  parameter int CIDX_W      = 3,
  parameter int SLOT_W      = 4,
  parameter int ENTRY_W     = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfl_pkg::POOL_W-1:0]    cfg_data,
  input  logic                          op_go,
  input  sfl_pkg::sfl_in_t              op,
  output sfl_pkg::sfl_dec_t             dec,
  output logic                          mem_we,
  output logic [CIDX_W+SLOT_W-1:0]      mem_waddr,
  output logic [ENTRY_W-1:0]            mem_wdata,
  output logic [CIDX_W+SLOT_W-1:0]      mem_raddr
);
  import sfl_pkg::*;

  localparam int NCLASS  = (MAX_CLASS >= MIN_CLASS) ? (MAX_CLASS - MIN_CLASS + 1) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int LIM_LOG = (ADDR_BITS < CAP_LOG) ? ADDR_BITS : CAP_LOG;
  localparam logic [POOL_W-1:0] LIMIT_CAP = POOL_W'(1) << LIM_LOG;

  logic [POOL_W-1:0] pool_r;
  logic [POOL_W-1:0] bump_r, bump_nxt, bump_after;
  logic [CNT_W-1:0]  cnt_r   [NCLASS];
  logic [CNT_W-1:0]  cnt_nxt [NCLASS];

  logic [CLASS_W-1:0] cls, old;
  logic               cls_ok, old_ok;
  logic [CIDX_W-1:0]  k_new, k_old, k_push;
  logic [CNT_W-1:0]   cnt_new, cnt_old, cnt_push;
  logic               full_new, full_old;
  logic [POOL_W-1:0]  bytes_new, limit;
  logic [POOL_W:0]    carve_sum;
  logic               carve_ok;
  logic [CNT_W-1:0]   pop_cnt;
  sfl_status_t        st;
  logic               pop, carve, push, flush;
  logic [COPY_W-1:0]  copy;

  assign cls    = op.size_class;
  assign old    = op.old_class;
  assign cls_ok = (cls >= CLASS_W'(MIN_CLASS)) && (cls <= CLASS_W'(MAX_CLASS));
  assign old_ok = (old >= CLASS_W'(MIN_CLASS)) && (old <= CLASS_W'(MAX_CLASS));
  assign k_new  = cls_ok ? CIDX_W'(cls - CLASS_W'(MIN_CLASS)) : '0;
  assign k_old  = old_ok ? CIDX_W'(old - CLASS_W'(MIN_CLASS)) : '0;

  assign cnt_new  = cnt_r[k_new];
  assign cnt_old  = cnt_r[k_old];
  assign full_new = cnt_new >= CNT_W'(STACK_DEPTH);
  assign full_old = cnt_old >= CNT_W'(STACK_DEPTH);

  assign bytes_new = POOL_W'(1) << cls;
  assign limit     = (pool_r < LIMIT_CAP) ? pool_r : LIMIT_CAP;
  assign carve_sum = {1'b0, bump_r} + {1'b0, bytes_new};
  assign carve_ok  = carve_sum <= {1'b0, limit};

  always_comb begin
    st     = ST_OK;
    pop    = 1'b0;
    carve  = 1'b0;
    push   = 1'b0;
    flush  = 1'b0;
    k_push = k_new;
    copy   = '0;
    case (op.func)
      FUNC_ALLOC: begin
        if (!cls_ok) begin
          st = ST_BADCLASS;
        end else if (cnt_new != '0) begin
          pop = 1'b1;
        end else if (carve_ok) begin
          carve = 1'b1;
        end else begin
          st = ST_OOM;
        end
      end
      FUNC_GROW: begin
        k_push = k_old;
        if (old >= cls) begin
          st = ST_NOTLARGER;
        end else if (!old_ok || !cls_ok) begin
          st = ST_BADCLASS;
        end else if (full_old) begin
          st = ST_FULL;
        end else if (cnt_new != '0 || carve_ok) begin
          pop   = cnt_new != '0;
          carve = cnt_new == '0;
          push  = 1'b1;
          copy  = COPY_W'(1) << old;
        end else begin
          st = ST_OOM;
        end
      end
      FUNC_FREE: begin
        if (!cls_ok) begin
          st = ST_BADCLASS;
        end else if (full_new) begin
          st = ST_FULL;
        end else begin
          push = 1'b1;
        end
      end
      FUNC_FLUSH: begin
        flush = 1'b1;
      end
    endcase
  end

  assign cnt_push   = cnt_r[k_push];
  assign pop_cnt    = cnt_new - CNT_W'(1);
  assign bump_after = flush ? '0 : (carve ? carve_sum[POOL_W-1:0] : bump_r);
  assign bump_nxt   = op_go ? bump_after : bump_r;

  always_comb begin
    for (int i = 0; i < NCLASS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (op_go) begin
        if (flush) begin
          cnt_nxt[i] = '0;
        end else begin
          if (pop && (CIDX_W'(i) == k_new)) begin
            cnt_nxt[i] = cnt_r[i] - CNT_W'(1);
          end
          if (push && (CIDX_W'(i) == k_push)) begin
            cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RESET;
      bump_r <= '0;
      cnt_r  <= '{default: '0};
    end else begin
      if (cfg_we) begin
        pool_r <= cfg_data;
      end
      bump_r <= bump_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign mem_we    = op_go && push;
  assign mem_waddr = {k_push, cnt_push[SLOT_W-1:0]};
  assign mem_wdata = op.location[ENTRY_W-1:0];
  assign mem_raddr = {k_new, pop_cnt[SLOT_W-1:0]};

  assign dec.status     = st;
  assign dec.from_mem   = pop;
  assign dec.carve_addr = carve ? bump_r[ADDR_W-1:0] : '0;
  assign dec.copy_bytes = copy;
  assign dec.used_bytes = bump_after;

endmodule
